// ===== design/msgd_pkg.sv =====
// shared types, constants and arithmetic helpers for the momentum sgd update pipeline
`timescale 1ns / 1ps

package msgd_pkg;

	localparam int DATA_W      = 32;
	localparam int FACTOR_W    = 16;
	localparam int CFG_INDEX_W = 4;

	// long division of the gradient magnitude, a few quotient bits per stage
	localparam int DIV_BITS_PER_STAGE = 4;
	localparam int DIV_STAGES         = DATA_W / DIV_BITS_PER_STAGE;

	// widths of the intermediate values
	localparam int SUM_W  = DATA_W + 1;
	localparam int PROD_W = SUM_W + FACTOR_W + 1;
	localparam int RS_W   = PROD_W - FACTOR_W;
	localparam int DIFF_W = RS_W + 1;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_LEARNING_RATE   = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_MOMENTUM_FACTOR = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] REG_DECAY_FACTOR    = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_BATCH_SIZE      = CFG_INDEX_W'(3);

	localparam logic [FACTOR_W-1:0] LEARNING_RATE_RST   = FACTOR_W'(655);
	localparam logic [FACTOR_W-1:0] MOMENTUM_FACTOR_RST = FACTOR_W'(58982);
	localparam logic [FACTOR_W-1:0] DECAY_FACTOR_RST    = FACTOR_W'(0);
	localparam logic [FACTOR_W-1:0] BATCH_SIZE_RST      = FACTOR_W'(1);

	// values that ride along with the division
	typedef struct packed {
		logic signed [DATA_W-1:0] p;
		logic signed [DATA_W-1:0] d;
		logic signed [DATA_W-1:0] mv;
		logic                     neg;
		logic                     last;
	} side_t;

	// divider state: partial remainder and the dividend turning into the quotient
	typedef struct packed {
		logic [FACTOR_W-1:0] rem;
		logic [DATA_W-1:0]   quo;
		side_t               side;
	} div_t;

	function automatic div_t div_step(input div_t x, input logic [FACTOR_W-1:0] dvs);
		div_t            r;
		logic [FACTOR_W:0] t;
		r = x;
		for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
			t = {r.rem, r.quo[DATA_W-1]};
			r.quo = {r.quo[DATA_W-2:0], 1'b0};
			if (t >= {1'b0, dvs}) begin
				t = t - {1'b0, dvs};
				r.quo[0] = 1'b1;
			end
			r.rem = t[FACTOR_W-1:0];
		end
		return r;
	endfunction

	// clamp to the signed data range
	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [DIFF_W-1:0] x);
		logic signed [DATA_W-1:0] r;
		if (x[DIFF_W-1:DATA_W-1] != {(DIFF_W-DATA_W+1){x[DIFF_W-1]}}) begin
			r = x[DIFF_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			r = x[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== design/momentum_sgd_update.sv =====
// top level of the momentum sgd update: configuration registers and the pipeline
`timescale 1ns / 1ps

//  channel  handshake               payload
//  cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//  in       in_valid / in_ready     param_value, velocity_in, grad_sum, is_bias, last_item
//  out      out_valid / out_ready   param_new, velocity_out, last_out
//
//  one item per cycle sustained while out_ready stays high; each result passes through
//  one product stage, eight 4-bit divider stages and four tail stages
//  every stage has its own valid and ready, so bubbles fill while the output stalls
//  arst_n clears all valid bits and loads the register reset values; cfg_ready stays high
//  registers are read live by the stages, so they must be written only with the pipe
//  empty; the block itself does not enforce this

module momentum_sgd_update import msgd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_W-1:0]     cfg_index,
	input  logic [FACTOR_W-1:0]        cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [DATA_W-1:0]   param_value,
	input  logic signed [DATA_W-1:0]   velocity_in,
	input  logic signed [DATA_W-1:0]   grad_sum,
	input  logic                       is_bias,
	input  logic                       last_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [DATA_W-1:0]   param_new,
	output logic signed [DATA_W-1:0]   velocity_out,
	output logic                       last_out
);

	logic [FACTOR_W-1:0] learning_rate_q;
	logic [FACTOR_W-1:0] momentum_factor_q;
	logic [FACTOR_W-1:0] decay_factor_q;
	logic [FACTOR_W-1:0] batch_size_q;
	logic [FACTOR_W-1:0] divisor;

	logic fr_valid, fr_ready;
	div_t fr_data;
	logic dv_valid, dv_ready;
	div_t dv_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learning_rate_q   <= LEARNING_RATE_RST;
			momentum_factor_q <= MOMENTUM_FACTOR_RST;
			decay_factor_q    <= DECAY_FACTOR_RST;
			batch_size_q      <= BATCH_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LEARNING_RATE:   learning_rate_q   <= cfg_data;
				REG_MOMENTUM_FACTOR: momentum_factor_q <= cfg_data;
				REG_DECAY_FACTOR:    decay_factor_q    <= cfg_data;
				REG_BATCH_SIZE:      batch_size_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// a zero batch size divides by one
	assign divisor = (batch_size_q == '0) ? FACTOR_W'(1) : batch_size_q;

	msgd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.param_value     (param_value),
		.velocity_in     (velocity_in),
		.grad_sum        (grad_sum),
		.is_bias         (is_bias),
		.last_item       (last_item),
		.decay_factor    (decay_factor_q),
		.momentum_factor (momentum_factor_q),
		.out_valid       (fr_valid),
		.out_ready       (fr_ready),
		.out_data        (fr_data)
	);

	msgd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_data   (fr_data),
		.divisor   (divisor),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.out_data  (dv_data)
	);

	msgd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (dv_valid),
		.in_ready      (dv_ready),
		.in_data       (dv_data),
		.learning_rate (learning_rate_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.param_new     (param_new),
		.velocity_out  (velocity_out),
		.last_out      (last_out)
	);

`ifndef NO_ASSERTIONS
	// the entry only blocks when every stage is full and the output is held
	a_block_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready && fr_valid && dv_valid))
		else $error("input blocked while the pipeline has room");

	// a free output frees the whole ready chain
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> (in_ready && fr_ready && dv_ready))
		else $error("ready chain broken with output ready");

	// a held result stays put while the sink stalls
	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(velocity_out)
			&& $stable(param_new)))
		else $error("stalled result changed");
`endif

endmodule

// ===== design/msgd_front.sv =====
// entry stage: decay and momentum products, gradient magnitude for the divider
`timescale 1ns / 1ps

module msgd_front import msgd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [DATA_W-1:0]   param_value,
	input  logic signed [DATA_W-1:0]   velocity_in,
	input  logic signed [DATA_W-1:0]   grad_sum,
	input  logic                       is_bias,
	input  logic                       last_item,
	input  logic [FACTOR_W-1:0]        decay_factor,
	input  logic [FACTOR_W-1:0]        momentum_factor,
	output logic                       out_valid,
	input  logic                       out_ready,
	output div_t                       out_data
);

	logic                                vld_s1;
	div_t                                data_s1;
	logic signed [DATA_W+FACTOR_W-1:0]   dprod;
	logic signed [DATA_W+FACTOR_W-1:0]   mprod;
	div_t                                nxt;

	assign dprod = $signed({1'b0, decay_factor}) * param_value;
	assign mprod = $signed({1'b0, momentum_factor}) * velocity_in;

	always_comb begin
		nxt.rem       = '0;
		nxt.quo       = grad_sum[DATA_W-1] ? (~grad_sum + DATA_W'(1)) : grad_sum;
		nxt.side.p    = param_value;
		// floor of the product by 2^16 is the upper slice
		nxt.side.d    = is_bias ? '0 : dprod[DATA_W+FACTOR_W-1:FACTOR_W];
		nxt.side.mv   = mprod[DATA_W+FACTOR_W-1:FACTOR_W];
		nxt.side.neg  = grad_sum[DATA_W-1];
		nxt.side.last = last_item;
	end

	assign in_ready  = !vld_s1 || out_ready;
	assign out_valid = vld_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ===== design/msgd_div.sv =====
// pipelined restoring divider for grad_sum / batch_size, sideband carried along
`timescale 1ns / 1ps

module msgd_div import msgd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  div_t                in_data,
	input  logic [FACTOR_W-1:0] divisor,
	output logic                out_valid,
	input  logic                out_ready,
	output div_t                out_data
);

	// stages s2 .. s9 of the whole pipeline
	logic [DIV_STAGES-1:0] vld_sd;
	logic [DIV_STAGES-1:0] rdy;
	div_t                  data_sd [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic nxt_rdy;
		logic prv_vld;
		div_t prv_data;

		if (k == DIV_STAGES - 1) begin : g_last
			assign nxt_rdy = out_ready;
		end else begin : g_mid
			assign nxt_rdy = rdy[k+1];
		end

		if (k == 0) begin : g_first
			assign prv_vld  = in_valid;
			assign prv_data = in_data;
		end else begin : g_rest
			assign prv_vld  = vld_sd[k-1];
			assign prv_data = data_sd[k-1];
		end

		assign rdy[k] = !vld_sd[k] || nxt_rdy;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_sd[k] <= prv_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && prv_vld) begin
				data_sd[k] <= div_step(prv_data, divisor);
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_sd[DIV_STAGES-1];
	assign out_data  = data_sd[DIV_STAGES-1];

endmodule

// ===== design/msgd_back.sv =====
// tail stages: signed quotient plus decay, rate product, velocity and parameter saturation
`timescale 1ns / 1ps

module msgd_back import msgd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  div_t                     in_data,
	input  logic [FACTOR_W-1:0]      learning_rate,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] param_new,
	output logic signed [DATA_W-1:0] velocity_out,
	output logic                     last_out
);

	logic                     vld_s10, vld_s11, vld_s12, vld_s13;
	logic                     rdy_s10, rdy_s11, rdy_s12, rdy_s13;

	logic signed [SUM_W-1:0]  sum_s10;
	logic signed [DATA_W-1:0] p_s10, mv_s10;
	logic                     last_s10;

	logic signed [RS_W-1:0]   rs_s11;
	logic signed [DATA_W-1:0] p_s11, mv_s11;
	logic                     last_s11;

	logic signed [DATA_W-1:0] vel_s12, p_s12;
	logic                     last_s12;

	logic signed [DATA_W-1:0] pnew_s13, vel_s13;
	logic                     last_s13;

	logic signed [SUM_W-1:0]  qmag;
	logic signed [SUM_W-1:0]  qsgn;
	logic signed [PROD_W-1:0] prod;
	logic signed [DIFF_W-1:0] vdiff;
	logic signed [DIFF_W-1:0] psum;

	assign rdy_s13 = !vld_s13 || out_ready;
	assign rdy_s12 = !vld_s12 || rdy_s13;
	assign rdy_s11 = !vld_s11 || rdy_s12;
	assign rdy_s10 = !vld_s10 || rdy_s11;
	assign in_ready = rdy_s10;

	// truncation toward zero: divide magnitudes, then restore the sign
	assign qmag  = $signed({1'b0, in_data.quo});
	assign qsgn  = in_data.side.neg ? -qmag : qmag;
	assign prod  = $signed({1'b0, learning_rate}) * sum_s10;
	assign vdiff = DIFF_W'(mv_s11) - DIFF_W'(rs_s11);
	assign psum  = DIFF_W'(p_s12) + DIFF_W'(vel_s12);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else begin
			if (rdy_s10) begin
				vld_s10 <= in_valid;
			end
			if (rdy_s11) begin
				vld_s11 <= vld_s10;
			end
			if (rdy_s12) begin
				vld_s12 <= vld_s11;
			end
			if (rdy_s13) begin
				vld_s13 <= vld_s12;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s10 && in_valid) begin
			sum_s10  <= qsgn + SUM_W'(in_data.side.d);
			p_s10    <= in_data.side.p;
			mv_s10   <= in_data.side.mv;
			last_s10 <= in_data.side.last;
		end
		if (rdy_s11 && vld_s10) begin
			rs_s11   <= prod[PROD_W-1:FACTOR_W];
			p_s11    <= p_s10;
			mv_s11   <= mv_s10;
			last_s11 <= last_s10;
		end
		if (rdy_s12 && vld_s11) begin
			vel_s12  <= sat_data(vdiff);
			p_s12    <= p_s11;
			last_s12 <= last_s11;
		end
		if (rdy_s13 && vld_s12) begin
			pnew_s13 <= sat_data(psum);
			vel_s13  <= vel_s12;
			last_s13 <= last_s12;
		end
	end

	assign out_valid    = vld_s13;
	assign param_new    = pnew_s13;
	assign velocity_out = vel_s13;
	assign last_out     = last_s13;

endmodule
